[rtl/mld_pkg.sv]
// Shared types and constants for the Maidenhead locator decoder.
// No dependencies; used by every module of the block.
package mld_pkg;

    localparam int unsigned NUM_CHARS = 10;
    localparam int unsigned NUM_PAIRS = 5;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned WGT_W     = 5;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned COORD_W   = 21;
    localparam int unsigned FINE_W    = 13;

    // Pair weights in output units, same for both axes
    localparam logic [COORD_W-1:0] C_WGT_FIELD  = 21'd57600;
    localparam logic [COORD_W-1:0] C_WGT_SQUARE = 21'd5760;
    localparam logic [FINE_W-1:0]  C_WGT_SUB    = 13'd240;
    localparam logic [FINE_W-1:0]  C_WGT_EXT    = 13'd24;

    // -518400 in two's complement, 21 bits
    localparam logic [COORD_W-1:0] C_ORIGIN = 21'h181700;

    typedef logic [NUM_PAIRS-1:0][WGT_W-1:0] t_wgt;

    typedef struct packed {
        logic vld;
        logic ok;
        t_wgt lat_w;
        t_wgt lon_w;
    } t_front;

endpackage

[rtl/mld_front.sv]
// Input stage: padding, reserved-word and class checks, character weights.
// Depends on mld_pkg.
module mld_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [mld_pkg::LEN_W-1:0]     i_length,
    input  logic [mld_pkg::NUM_CHARS-1:0][mld_pkg::CHAR_W-1:0] i_chars,
    output mld_pkg::t_front               o_front
);

    localparam logic [mld_pkg::CHAR_W-1:0] CH_L = 8'h4C;
    localparam logic [mld_pkg::CHAR_W-1:0] CH_5 = 8'h35;
    localparam logic [mld_pkg::CHAR_W-1:0] CH_A = 8'h41;
    localparam logic [mld_pkg::CHAR_W-1:0] CH_Z = 8'h5A;
    localparam logic [mld_pkg::CHAR_W-1:0] CH_LA = 8'h61;
    localparam logic [mld_pkg::CHAR_W-1:0] CH_LZ = 8'h7A;
    localparam logic [mld_pkg::CHAR_W-1:0] CH_0 = 8'h30;
    localparam logic [mld_pkg::CHAR_W-1:0] CH_9 = 8'h39;
    localparam logic [mld_pkg::CHAR_W-1:0] CH_UPPER_MASK = 8'hDF;
    // "RR73", "TU73", "JT65", first character in the low byte
    localparam logic [31:0] WORD_RR73 = 32'h3337_5252;
    localparam logic [31:0] WORD_TU73 = 32'h3337_5554;
    localparam logic [31:0] WORD_JT65 = 32'h3536_544A;
    localparam logic [mld_pkg::LEN_W-1:0] LEN_MIN = 4'd4;
    localparam logic [mld_pkg::LEN_W-1:0] LEN_MAX = 4'd10;

    mld_pkg::t_front r_front;
    mld_pkg::t_front n_front;

    logic [mld_pkg::NUM_CHARS-1:0][mld_pkg::CHAR_W-1:0] s;
    logic [mld_pkg::NUM_CHARS-1:0]                      cls_ok;
    logic [mld_pkg::NUM_CHARS-1:0][mld_pkg::CHAR_W-1:0] wgt8;
    logic [31:0]                                        head;
    logic                                               len_ok;
    logic                                               reserved;

    always_comb begin
        for (int i = 0; i < mld_pkg::NUM_CHARS; i++) begin
            logic letter_pos;
            logic [mld_pkg::CHAR_W-1:0] up;
            letter_pos = (((i >> 1) & 1) == 0);
            s[i] = (4'(i) < i_length) ? i_chars[i] : (letter_pos ? CH_L : CH_5);
            up = s[i] & CH_UPPER_MASK;
            if (letter_pos) begin
                cls_ok[i] = ((s[i] >= CH_A) && (s[i] <= CH_Z)) ||
                            ((s[i] >= CH_LA) && (s[i] <= CH_LZ));
                wgt8[i]   = up - CH_A;
            end else begin
                cls_ok[i] = (s[i] >= CH_0) && (s[i] <= CH_9);
                wgt8[i]   = s[i] - CH_0;
            end
        end
        head     = {i_chars[3], i_chars[2], i_chars[1], i_chars[0]};
        len_ok   = (i_length >= LEN_MIN) && (i_length <= LEN_MAX);
        reserved = (head == WORD_RR73) || (head == WORD_TU73) || (head == WORD_JT65);

        n_front.vld = i_vld;
        n_front.ok  = len_ok && !reserved && (&cls_ok);
        for (int p = 0; p < mld_pkg::NUM_PAIRS; p++) begin
            n_front.lon_w[p] = wgt8[2*p][mld_pkg::WGT_W-1:0];
            n_front.lat_w[p] = wgt8[2*p+1][mld_pkg::WGT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_front.ok    <= n_front.ok;
        r_front.lat_w <= n_front.lat_w;
        r_front.lon_w <= n_front.lon_w;
        if (!i_rst_n) begin
            r_front.vld <= 1'b0;
        end else begin
            r_front.vld <= n_front.vld;
        end
    end

    assign o_front = r_front;

endmodule

[rtl/mld_axis.sv]
// Two-stage weighted sum for one axis: partial sums, then origin and zeroing.
// Depends on mld_pkg.
module mld_axis (
    input  logic                               i_clk,
    input  mld_pkg::t_wgt                      i_wgt,
    input  logic                               i_ok,
    output logic signed [mld_pkg::COORD_W-1:0] o_coord
);

    logic [mld_pkg::COORD_W-1:0] r_coarse, n_coarse;
    logic [mld_pkg::FINE_W-1:0]  r_fine, n_fine;
    logic                        r_ok;
    logic [mld_pkg::COORD_W-1:0] r_coord, n_coord;

    // field and square pairs, then subsquare, extended and fine
    assign n_coarse = mld_pkg::C_WGT_FIELD  * mld_pkg::COORD_W'(i_wgt[0])
                    + mld_pkg::C_WGT_SQUARE * mld_pkg::COORD_W'(i_wgt[1]);
    assign n_fine   = mld_pkg::C_WGT_SUB * mld_pkg::FINE_W'(i_wgt[2])
                    + mld_pkg::C_WGT_EXT * mld_pkg::FINE_W'(i_wgt[3])
                    + mld_pkg::FINE_W'(i_wgt[4]);

    // wraps mod 2^21; the true result always fits
    assign n_coord = r_ok ? (mld_pkg::C_ORIGIN + r_coarse + mld_pkg::COORD_W'(r_fine))
                          : '0;

    always_ff @(posedge i_clk) begin
        r_coarse <= n_coarse;
        r_fine   <= n_fine;
        r_ok     <= i_ok;
        r_coord  <= n_coord;
    end

    assign o_coord = signed'(r_coord);

endmodule

[rtl/maidenhead_locator_decode.sv]
// Top level of the Maidenhead locator decoder: check stage and two axis sums.
// Depends on mld_pkg, mld_front and mld_axis.
// One locator per cycle. start goes through mld_front, r_vld[0] and r_vld[1]
// to o_strobe. busy is always low; results appear for one cycle and cannot be
// stalled. Reset (synchronous, active low) clears the valid pipeline only.
module maidenhead_locator_decode (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [3:0]                         i_length,
    input  logic [7:0]                         i_char0,
    input  logic [7:0]                         i_char1,
    input  logic [7:0]                         i_char2,
    input  logic [7:0]                         i_char3,
    input  logic [7:0]                         i_char4,
    input  logic [7:0]                         i_char5,
    input  logic [7:0]                         i_char6,
    input  logic [7:0]                         i_char7,
    input  logic [7:0]                         i_char8,
    input  logic [7:0]                         i_char9,
    output logic                               o_strobe,
    output logic                               o_ok,
    output logic signed [20:0]                 o_latitude,
    output logic signed [20:0]                 o_longitude
);

    logic [mld_pkg::NUM_CHARS-1:0][mld_pkg::CHAR_W-1:0] chars;
    mld_pkg::t_front front;
    logic [1:0] r_vld;
    logic [1:0] r_ok;

    assign busy  = 1'b0;
    assign chars = {i_char9, i_char8, i_char7, i_char6, i_char5,
                    i_char4, i_char3, i_char2, i_char1, i_char0};

    mld_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (start && !busy),
        .i_length (i_length),
        .i_chars  (chars),
        .o_front  (front)
    );

    mld_axis u_lat (
        .i_clk   (i_clk),
        .i_wgt   (front.lat_w),
        .i_ok    (front.ok),
        .o_coord (o_latitude)
    );

    mld_axis u_lon (
        .i_clk   (i_clk),
        .i_wgt   (front.lon_w),
        .i_ok    (front.ok),
        .o_coord (o_longitude)
    );

    always_ff @(posedge i_clk) begin
        r_ok <= {r_ok[0], front.ok};
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], front.vld};
        end
    end

    assign o_strobe = r_vld[1];
    assign o_ok     = r_ok[1];

endmodule
